// ===== sv/p1ts_pkg.sv =====
// Shared widths, lane pairing and payload types for the P1 triangle stiffness block.
package p1ts_pkg;

	localparam int CW        = 32;           // input coordinate width
	localparam int EW        = CW + 1;       // edge component width
	localparam int PW        = 2 * EW;       // edge product width
	localparam int SW        = PW + 1;       // area / dot sum width
	localparam int MW        = SW - 1;       // magnitude width
	localparam int DW        = MW + 3;       // 6 * |area|
	localparam int SUM_W     = CW + 2;       // conductivity sum
	localparam int NUM_SHIFT = 64;           // sum sits at bit 64 of the dividend
	localparam int QW        = SUM_W + NUM_SHIFT;
	localparam int DIV_N     = QW;           // one quotient bit per stage
	localparam int LIMB      = 14;
	localparam int NLIMB     = QW / LIMB;
	localparam int PRW       = QW + MW;
	localparam int FRAC      = 48;
	localparam int OW        = 64;
	localparam int NE        = 6;            // three diagonal, three off-diagonal

	localparam int PAIR_I [NE] = '{0, 1, 2, 0, 0, 1};
	localparam int PAIR_J [NE] = '{0, 1, 2, 1, 2, 2};

	localparam logic [OW-1:0] SAT_POS = {1'b0, {(OW-1){1'b1}}};
	localparam logic [OW-1:0] SAT_NEG = {1'b1, {(OW-1){1'b0}}};

	typedef logic [MW-1:0] mag_t;

	typedef struct packed {
		mag_t [NE-1:0] dmag;
		logic [NE-1:0] eneg;
		logic          deg;
	} div_side_t;

endpackage

// ===== sv/p1ts_div.sv =====
// Restoring divider pipeline, one quotient bit per stage, for (sum << 64) / den.
module p1ts_div import p1ts_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  logic [SUM_W-1:0] num_hi,
	input  logic [DW-1:0]    den,
	input  div_side_t        side_in,
	output logic             out_valid,
	output logic [QW-1:0]    quo,
	output div_side_t        side_out
);

	logic             v_s    [DIV_N+1];
	logic [DW-1:0]    rem_s  [DIV_N+1];
	logic [DW-1:0]    den_s  [DIV_N+1];
	logic [QW-1:0]    q_s    [DIV_N+1];
	logic [SUM_W-1:0] num_s  [DIV_N+1];
	div_side_t        side_s [DIV_N+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= DIV_N; i++) v_s[i] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
			for (int i = 0; i < DIV_N; i++) v_s[i+1] <= v_s[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= '0;
			q_s[0]    <= '0;
			den_s[0]  <= den;
			num_s[0]  <= num_hi;
			side_s[0] <= side_in;
		end
	end

	for (genvar k = 0; k < DIV_N; k++) begin : g_stage
		localparam int NB = QW - 1 - k;
		logic        nbit;
		logic [DW:0] trial;
		logic [DW:0] diff;
		logic        ge;

		if (NB >= NUM_SHIFT) begin : g_bit
			assign nbit = num_s[k][NB-NUM_SHIFT];
		end else begin : g_zero
			assign nbit = 1'b0;
		end

		assign trial = {rem_s[k], nbit};
		assign diff  = trial - {1'b0, den_s[k]};
		assign ge    = trial >= {1'b0, den_s[k]};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
				q_s[k+1]    <= {q_s[k][QW-2:0], ge};
				den_s[k+1]  <= den_s[k];
				num_s[k+1]  <= num_s[k];
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_valid = v_s[DIV_N];
	assign quo       = q_s[DIV_N];
	assign side_out  = side_s[DIV_N];

endmodule

// ===== sv/p1ts_mul.sv =====
// Limb-serial pipelined multiplier: quotient times dot magnitude, 14 bits per stage.
module p1ts_mul import p1ts_pkg::*; (
	input  logic           clk,
	input  logic           en,
	input  logic [QW-1:0]  fac,
	input  mag_t           dmag,
	output logic [PRW-1:0] prod
);

	logic [QW-1:0]  fac_s  [NLIMB];
	mag_t           dmag_s [NLIMB];
	logic [PRW-1:0] acc_s  [NLIMB+1];

	always_ff @(posedge clk) begin
		if (en) begin
			fac_s[0]  <= fac;
			dmag_s[0] <= dmag;
			acc_s[0]  <= '0;
		end
	end

	for (genvar k = 0; k < NLIMB; k++) begin : g_stage
		logic [LIMB-1:0]    limb;
		logic [LIMB+MW-1:0] pp;

		assign limb = fac_s[k][(NLIMB-k)*LIMB-1 -: LIMB];
		assign pp   = limb * dmag_s[k];

		always_ff @(posedge clk) begin
			if (en) begin
				acc_s[k+1] <= (acc_s[k] << LIMB) + PRW'(pp);
			end
		end

		if (k < NLIMB - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					fac_s[k+1]  <= fac_s[k];
					dmag_s[k+1] <= dmag_s[k];
				end
			end
		end
	end

	assign prod = acc_s[NLIMB];

endmodule

// ===== sv/p1_triangle_stiffness.sv =====
// Top level: P1 triangle local stiffness matrix, fully pipelined.
//
//  channel | handshake              | beat contents
//  --------+------------------------+--------------------------------------------
//  in      | in_valid / in_stall    | x1 y1 x2 y2 x3 y3 (Q16.16), cond1..cond3
//  out     | out_valid / out_stall  | diag_1..3, offdiag_12/13/23 (Q32.32), degenerate
//
// One beat per cycle while no output beat is held by out_stall. Pipeline: 4 geometry stages,
// 99 divider stages, 8 multiplier stages, output register; the divider makes up most of the depth.
// Reset clears all valid bits. A stalled output holds the whole pipeline; in_stall
// follows out_stall while an output beat is waiting.
module p1_triangle_stiffness import p1ts_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic signed [CW-1:0] x1,
	input  logic signed [CW-1:0] y1,
	input  logic signed [CW-1:0] x2,
	input  logic signed [CW-1:0] y2,
	input  logic signed [CW-1:0] x3,
	input  logic signed [CW-1:0] y3,
	input  logic        [CW-1:0] cond1,
	input  logic        [CW-1:0] cond2,
	input  logic        [CW-1:0] cond3,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic signed [OW-1:0] diag_1,
	output logic signed [OW-1:0] diag_2,
	output logic signed [OW-1:0] diag_3,
	output logic signed [OW-1:0] offdiag_12,
	output logic signed [OW-1:0] offdiag_13,
	output logic signed [OW-1:0] offdiag_23,
	output logic                 degenerate
);

	logic en;

	logic                 v_s1, v_s2, v_s3, v_s4;
	logic signed [EW-1:0] dx_s1 [3];
	logic signed [EW-1:0] dy_s1 [3];
	logic [SUM_W-1:0]     sum_s1, sum_s2, sum_s3, sum_s4;
	logic signed [PW-1:0] pa_s2, pb_s2;
	logic signed [PW-1:0] px_s2 [NE];
	logic signed [PW-1:0] py_s2 [NE];
	logic signed [SW-1:0] area_s3;
	logic signed [SW-1:0] dot_s3 [NE];
	logic [DW-1:0]        den_s4;
	div_side_t            side_s4;

	mag_t                 amag;
	div_side_t            side_c;

	logic                 div_v;
	logic [QW-1:0]        div_q;
	div_side_t            div_side;

	logic                 tv_s   [NLIMB+1];
	logic [NE-1:0]        tneg_s [NLIMB+1];
	logic                 tdeg_s [NLIMB+1];
	logic [PRW-1:0]       prod   [NE];

	logic [OW-1:0]        ent    [NE];
	logic                 out_valid_q, deg_q;
	logic [OW-1:0]        ent_q  [NE];

	assign en       = !(out_valid_q && out_stall);
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// edges d1 = p3-p2, d2 = p1-p3, d3 = p2-p1
	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1[0] <= EW'(x3) - EW'(x2);
			dy_s1[0] <= EW'(y3) - EW'(y2);
			dx_s1[1] <= EW'(x1) - EW'(x3);
			dy_s1[1] <= EW'(y1) - EW'(y3);
			dx_s1[2] <= EW'(x2) - EW'(x1);
			dy_s1[2] <= EW'(y2) - EW'(y1);
			sum_s1   <= SUM_W'(cond1) + SUM_W'(cond2) + SUM_W'(cond3);

			pa_s2  <= dx_s1[0] * dy_s1[1];
			pb_s2  <= dy_s1[0] * dx_s1[1];
			sum_s2 <= sum_s1;
			for (int e = 0; e < NE; e++) begin
				px_s2[e] <= dx_s1[PAIR_I[e]] * dx_s1[PAIR_J[e]];
				py_s2[e] <= dy_s1[PAIR_I[e]] * dy_s1[PAIR_J[e]];
			end

			area_s3 <= SW'(pa_s2) - SW'(pb_s2);
			sum_s3  <= sum_s2;
			for (int e = 0; e < NE; e++) begin
				dot_s3[e] <= SW'(px_s2[e]) + SW'(py_s2[e]);
			end

			den_s4  <= DW'({amag, 2'b00}) + DW'({amag, 1'b0});
			side_s4 <= side_c;
			sum_s4  <= sum_s3;
		end
	end

	always_comb begin
		amag = area_s3[SW-1] ? MW'(-area_s3) : MW'(area_s3);
		for (int e = 0; e < NE; e++) begin
			side_c.dmag[e] = dot_s3[e][SW-1] ? MW'(-dot_s3[e]) : MW'(dot_s3[e]);
			side_c.eneg[e] = area_s3[SW-1] ^ dot_s3[e][SW-1];
		end
		side_c.deg = (area_s3 == '0);
	end

	p1ts_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s4),
		.num_hi   (sum_s4),
		.den      (den_s4),
		.side_in  (side_s4),
		.out_valid(div_v),
		.quo      (div_q),
		.side_out (div_side)
	);

	for (genvar e = 0; e < NE; e++) begin : g_lane
		p1ts_mul u_mul (
			.clk (clk),
			.en  (en),
			.fac (div_q),
			.dmag(div_side.dmag[e]),
			.prod(prod[e])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= NLIMB; i++) tv_s[i] <= 1'b0;
		end else if (en) begin
			tv_s[0] <= div_v;
			for (int i = 0; i < NLIMB; i++) tv_s[i+1] <= tv_s[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tneg_s[0] <= div_side.eneg;
			tdeg_s[0] <= div_side.deg;
			for (int i = 0; i < NLIMB; i++) begin
				tneg_s[i+1] <= tneg_s[i];
				tdeg_s[i+1] <= tdeg_s[i];
			end
		end
	end

	// drop 48 fraction bits, apply sign, saturate to 64-bit signed; zero for degenerate triangles
	always_comb begin
		logic [PRW-FRAC-1:0] m;
		logic                pos_ovf;
		logic                neg_ovf;
		for (int e = 0; e < NE; e++) begin
			m       = prod[e][PRW-1:FRAC];
			pos_ovf = |m[PRW-FRAC-1:OW-1];
			neg_ovf = (|m[PRW-FRAC-1:OW]) || (m[OW-1] && (|m[OW-2:0]));
			if (tdeg_s[NLIMB]) begin
				ent[e] = '0;
			end else if (tneg_s[NLIMB][e]) begin
				ent[e] = neg_ovf ? SAT_NEG : -m[OW-1:0];
			end else begin
				ent[e] = pos_ovf ? SAT_POS : m[OW-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= tv_s[NLIMB];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			deg_q <= tdeg_s[NLIMB];
			for (int e = 0; e < NE; e++) ent_q[e] <= ent[e];
		end
	end

	assign out_valid  = out_valid_q;
	assign degenerate = deg_q;
	assign diag_1     = ent_q[0];
	assign diag_2     = ent_q[1];
	assign diag_3     = ent_q[2];
	assign offdiag_12 = ent_q[3];
	assign offdiag_13 = ent_q[4];
	assign offdiag_23 = ent_q[5];

`ifndef SYNTHESIS
	a_deg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> diag_1 == '0 && diag_2 == '0 && diag_3 == '0 &&
			offdiag_12 == '0 && offdiag_13 == '0 && offdiag_23 == '0)
		else $error("degenerate beat with nonzero entries");

	a_stall_link: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("input stall not tied to held output");

	a_pipe_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> $stable(v_s4) && $stable(tv_s[NLIMB]))
		else $error("pipeline moved during stall");
`endif

endmodule
